/* src/hbdt_pkg.sv */
// ----------------------------------------------------------------------------
// hbdt_pkg
// Shared types and constants for the h-bridge direction and dead-time block.
// ----------------------------------------------------------------------------
package hbdt_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned PCT_W       = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_TIME    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_LEFT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_RIGHT = 2'd2;

  localparam logic [15:0] DEAD_TIME_RESET = 16'd10;
  localparam logic [31:0] PERIOD_RESET    = 32'd50000;

  localparam logic [1:0] DIR_IDLE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_WAIT  = 2'd3;

  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_100   = 32'h51EB851F;
  localparam int unsigned RECIP_SHIFT = 37;
  // floor(y / 100) = (y * SMALL_RECIP) >> SMALL_SHIFT for y below 43699
  localparam logic [12:0] SMALL_RECIP = 13'd5243;
  localparam int unsigned SMALL_SHIFT = 19;

  localparam int unsigned QUOT_W = 64 - RECIP_SHIFT;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_LEFT  = 4'b0010,
    MODE_RIGHT = 4'b0100,
    MODE_WAIT  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic               command_valid;
    logic signed [15:0] command;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [31:0] pulse_left;
    logic [31:0] pulse_right;
    logic [1:0]  direction;
  } out_t;

  typedef struct packed {
    logic [15:0] dead_time_ms;
    logic [31:0] period_left;
    logic [31:0] period_right;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       direction;
    logic [PCT_W-1:0] pct;
    logic [31:0]      period;
  } stage_t;

endpackage

/* src/hbdt_regs.sv */
// ----------------------------------------------------------------------------
// hbdt_regs
// Configuration register file: dead time and the two pwm periods.
// ----------------------------------------------------------------------------
module hbdt_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hbdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hbdt_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_time_ms <= hbdt_pkg::DEAD_TIME_RESET;
      cfg.period_left  <= hbdt_pkg::PERIOD_RESET;
      cfg.period_right <= hbdt_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hbdt_pkg::CFG_DEAD_TIME:    cfg.dead_time_ms <= cfg_data[15:0];
        hbdt_pkg::CFG_PERIOD_LEFT:  cfg.period_left  <= cfg_data;
        hbdt_pkg::CFG_PERIOD_RIGHT: cfg.period_right <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/hbdt_dir_ctrl.sv */
// ----------------------------------------------------------------------------
// hbdt_dir_ctrl
// Direction state machine with dead-time wait, command hold and magnitude.
// ----------------------------------------------------------------------------
module hbdt_dir_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  hbdt_pkg::cfg_t   cfg,
  input  logic             item_valid,
  output logic             item_stall,
  input  hbdt_pkg::in_t    item,
  output logic             s1_valid,
  input  logic             s1_stall,
  output hbdt_pkg::stage_t s1
);

  hbdt_pkg::mode_t          mode;
  hbdt_pkg::mode_t          mode_next;
  logic signed [15:0]       held;
  logic signed [15:0]       held_next;
  logic [31:0]              wait_start;
  logic [31:0]              wait_start_next;
  logic                     neg;
  logic                     pos;
  logic [31:0]              elapsed;
  logic                     over;
  logic [16:0]              mag;
  logic [8:0]               mag_int;
  logic [hbdt_pkg::PCT_W-1:0] pct;
  hbdt_pkg::stage_t         s1_next;
  logic                     accept;

  assign item_stall = s1_valid && s1_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    held_next       = item.command_valid ? item.command : held;
    neg             = held_next[15];
    pos             = !neg && (held_next != 16'sd0);
    elapsed         = item.now_ms - wait_start;
    over            = elapsed > {16'd0, cfg.dead_time_ms};
    mode_next       = mode;
    wait_start_next = wait_start;
    case (mode)
      hbdt_pkg::MODE_IDLE: begin
        if (pos) begin
          mode_next = hbdt_pkg::MODE_LEFT;
        end else if (neg) begin
          mode_next = hbdt_pkg::MODE_RIGHT;
        end
      end
      hbdt_pkg::MODE_LEFT: begin
        if (!pos) begin
          mode_next       = hbdt_pkg::MODE_WAIT;
          wait_start_next = item.now_ms;
        end
      end
      hbdt_pkg::MODE_RIGHT: begin
        if (!neg) begin
          mode_next       = hbdt_pkg::MODE_WAIT;
          wait_start_next = item.now_ms;
        end
      end
      hbdt_pkg::MODE_WAIT: begin
        if (over) begin
          if (pos) begin
            mode_next = hbdt_pkg::MODE_LEFT;
          end else if (neg) begin
            mode_next = hbdt_pkg::MODE_RIGHT;
          end else begin
            mode_next = hbdt_pkg::MODE_IDLE;
          end
        end
      end
      default: mode_next = hbdt_pkg::MODE_IDLE;
    endcase
  end

  // integer percent, saturated at full scale
  always_comb begin
    mag     = neg ? (17'h10000 - {1'b0, held_next}) : {1'b0, held_next};
    mag_int = mag[16:8];
    pct     = (mag_int > {2'd0, hbdt_pkg::FULL_SCALE}) ? hbdt_pkg::FULL_SCALE
                                                       : mag_int[hbdt_pkg::PCT_W-1:0];
  end

  always_comb begin
    s1_next.pct    = '0;
    s1_next.period = '0;
    case (mode_next)
      hbdt_pkg::MODE_LEFT: begin
        s1_next.direction = hbdt_pkg::DIR_LEFT;
        s1_next.pct       = pct;
        s1_next.period    = cfg.period_left;
      end
      hbdt_pkg::MODE_RIGHT: begin
        s1_next.direction = hbdt_pkg::DIR_RIGHT;
        s1_next.pct       = pct;
        s1_next.period    = cfg.period_right;
      end
      hbdt_pkg::MODE_WAIT: s1_next.direction = hbdt_pkg::DIR_WAIT;
      default:             s1_next.direction = hbdt_pkg::DIR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= hbdt_pkg::MODE_IDLE;
      held       <= 16'sd0;
      wait_start <= 32'd0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        held       <= held_next;
        wait_start <= wait_start_next;
        s1_valid   <= 1'b1;
      end else if (!s1_stall) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

endmodule

/* src/hbdt_pulse_pipe.sv */
// ----------------------------------------------------------------------------
// hbdt_pulse_pipe
// Pipelined pulse width: period * pct / 100 via constant reciprocals.
// ----------------------------------------------------------------------------
module hbdt_pulse_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  output logic             s1_stall,
  input  hbdt_pkg::stage_t s1,
  output logic             result_valid,
  input  logic             result_stall,
  output hbdt_pkg::out_t   result
);

  localparam int unsigned QW = hbdt_pkg::QUOT_W;
  localparam int unsigned PW = hbdt_pkg::PCT_W;

  logic v2, v3, v4;
  logic take2, take3, take4, take5;

  // stage 2: quotient of period by 100
  logic [QW-1:0] q2;
  logic [31:0]   period2;
  logic [PW-1:0] pct2;
  logic [1:0]    dir2;
  logic [63:0]   recip_prod;

  // stage 3: remainder
  logic [QW-1:0] q3;
  logic [6:0]    r3;
  logic [PW-1:0] pct3;
  logic [1:0]    dir3;
  logic [33:0]   q_times;
  logic [31:0]   diff;

  // stage 4: partial products
  logic [31:0]   qm4;
  logic [13:0]   rm4;
  logic [1:0]    dir4;
  logic [33:0]   qm_full;

  // stage 5: fraction correction and sum
  logic [26:0]   frac_prod;
  logic [31:0]   pulse;

  assign take5    = !result_valid || !result_stall;
  assign take4    = !v4 || take5;
  assign take3    = !v3 || take4;
  assign take2    = !v2 || take3;
  assign s1_stall = !take2;

  assign recip_prod = {32'd0, s1.period} * {32'd0, hbdt_pkg::RECIP_100};
  assign q_times    = {{(34-QW){1'b0}}, q2} * 34'd100;
  assign diff       = period2 - q_times[31:0];
  assign qm_full    = {{(34-QW){1'b0}}, q3} * {27'd0, pct3};
  assign frac_prod  = {13'd0, rm4} * {14'd0, hbdt_pkg::SMALL_RECIP};
  assign pulse      = qm4 + {24'd0, frac_prod[hbdt_pkg::SMALL_SHIFT +: 8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take2) begin
        v2 <= s1_valid;
      end
      if (take3) begin
        v3 <= v2;
      end
      if (take4) begin
        v4 <= v3;
      end
      if (take5) begin
        result_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      q2      <= recip_prod[63:hbdt_pkg::RECIP_SHIFT];
      period2 <= s1.period;
      pct2    <= s1.pct;
      dir2    <= s1.direction;
    end
    if (take3) begin
      q3   <= q2;
      r3   <= diff[6:0];
      pct3 <= pct2;
      dir3 <= dir2;
    end
    if (take4) begin
      qm4  <= qm_full[31:0];
      rm4  <= {7'd0, r3} * {7'd0, pct3};
      dir4 <= dir3;
    end
    if (take5) begin
      result.direction   <= dir4;
      result.pulse_left  <= (dir4 == hbdt_pkg::DIR_LEFT) ? pulse : 32'd0;
      result.pulse_right <= (dir4 == hbdt_pkg::DIR_RIGHT) ? pulse : 32'd0;
    end
  end

endmodule

/* src/hbdt_direction_dead_time.sv */
// path: an item goes through s1, stages 2, 3 and 4 and the result register
// throughput: one item per cycle while result_stall is low; five register
//   stages, set by the reciprocal multiplies of the pulse-width path
// reset: synchronous, active high; mode idle, held command zero, dead time 10,
//   both periods 50000, pipeline empty
// ----------------------------------------------------------------------------
// hbridge_direction_dead_time
// H-bridge direction control with dead-time wait and pwm pulse widths.
// ----------------------------------------------------------------------------
module hbridge_direction_dead_time (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hbdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hbdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  hbdt_pkg::in_t                    item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output hbdt_pkg::out_t                   result
);

  hbdt_pkg::cfg_t   cfg;
  logic             s1_valid;
  logic             s1_stall;
  hbdt_pkg::stage_t s1;

  hbdt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hbdt_dir_ctrl u_dir_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .s1_valid   (s1_valid),
    .s1_stall   (s1_stall),
    .s1         (s1)
  );

  hbdt_pulse_pipe u_pulse_pipe (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_stall     (s1_stall),
    .s1           (s1),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pulse_left == 32'd0 || result.pulse_right == 32'd0))
    else $error("both pulse outputs active");

  a_left_dir: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pulse_left != 32'd0 |-> result.direction == hbdt_pkg::DIR_LEFT)
    else $error("left pulse outside left direction");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pulse_left <= cfg.period_left)
    else $error("left pulse exceeds period");

  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pulse_right <= cfg.period_right)
    else $error("right pulse exceeds period");
`endif

endmodule
